// ===== design/bsop_pkg.sv =====
// shared types and constants for the bitmap set operation unit
// no dependencies; imported by every module of the block
package bsop_pkg;

  localparam int DEF_MAX_WORDS = 255;

  localparam int MODE_W   = 4;
  localparam int IDX_W    = 8;
  localparam int WORD_W   = 16;
  localparam int ELEM_W   = 16;
  localparam int BITSEL_W = 4;

  // stream payload layout
  localparam int S_TDATA_W = 72;
  localparam int M_OUT_W   = 2 + WORD_W + IDX_W;
  localparam int M_TDATA_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_WR_A     = 4'd0,
    MODE_WR_B     = 4'd1,
    MODE_SIZE_A   = 4'd2,
    MODE_SIZE_B   = 4'd3,
    MODE_UNION    = 4'd4,
    MODE_INTER    = 4'd5,
    MODE_DIFF     = 4'd6,
    MODE_EQUAL    = 4'd7,
    MODE_SUBSET   = 4'd8,
    MODE_SUPERSET = 4'd9,
    MODE_MEMBER   = 4'd10,
    MODE_SUBRANGE = 4'd11,
    MODE_ADJUST   = 4'd12,
    MODE_RD_A     = 4'd13
  } mode_t;

  typedef struct packed {
    logic capture;
    logic setup;
    logic walk;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic walk_needed;
    logic walk_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/bsop_ctrl.sv =====
// sequencer for the bitmap set operation unit
// depends on bsop_pkg; drives the datapath through cmd_t, reads sts_t
module bsop_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bsop_pkg::sts_t  sts,
  output bsop_pkg::cmd_t  cmd
);
  import bsop_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && !sts.clearing) state <= ST_SETUP;
        end
        ST_SETUP: begin
          state <= sts.walk_needed ? ST_WALK : ST_FINISH;
        end
        ST_WALK: begin
          if (sts.walk_last) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (sts.out_free) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // no item is taken while the stores are being cleared
  assign in_ready    = (state == ST_IDLE) && !sts.clearing;
  assign cmd.capture = in_ready && in_valid;
  assign cmd.setup   = (state == ST_SETUP);
  assign cmd.walk    = (state == ST_WALK);
  assign cmd.commit  = (state == ST_FINISH) && sts.out_free;

endmodule

// ===== design/bsop_dp.sv =====
// datapath: word stores for sets a and b, sizes, walk counter, result register
// depends on bsop_pkg; sequenced by bsop_ctrl
module bsop_dp #(
  parameter int MAX_WORDS = bsop_pkg::DEF_MAX_WORDS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bsop_pkg::cmd_t                  cmd,
  output bsop_pkg::sts_t                  sts,
  input  logic [bsop_pkg::MODE_W-1:0]     in_mode,
  input  logic [bsop_pkg::IDX_W-1:0]      in_word_index,
  input  logic [bsop_pkg::WORD_W-1:0]     in_data_word,
  input  logic [bsop_pkg::ELEM_W-1:0]     in_size_request,
  input  logic [bsop_pkg::ELEM_W-1:0]     in_element_low,
  input  logic [bsop_pkg::ELEM_W-1:0]     in_element_high,
  input  logic                            cfg_valid,
  input  logic                            cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            out_ok,
  output logic                            out_answer,
  output logic [bsop_pkg::WORD_W-1:0]     out_read_word,
  output logic [bsop_pkg::IDX_W-1:0]      out_size_now
);
  import bsop_pkg::*;

  localparam int AW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int WIDX_W = ELEM_W - BITSEL_W;
  localparam logic [IDX_W-1:0]  MAX_IDX  = IDX_W'(MAX_WORDS);
  localparam logic [ELEM_W-1:0] MAX_REQ  = ELEM_W'(MAX_WORDS);
  localparam logic [ELEM_W-1:0] MAX_ELEM = ELEM_W'(MAX_WORDS * WORD_W);
  localparam logic [AW-1:0]     CLR_LAST = AW'(MAX_WORDS - 1);

  // item registers
  mode_t              mode_r;
  logic [IDX_W-1:0]   widx_r;
  logic [WORD_W-1:0]  data_r;
  logic [ELEM_W-1:0]  req_r;
  logic [ELEM_W-1:0]  lo_r;
  logic [ELEM_W-1:0]  hi_r;

  logic               trim_r;
  logic [IDX_W-1:0]   size_a;
  logic [IDX_W-1:0]   size_b;

  // word stores, zeroed by a clearing pass after reset
  logic [WORD_W-1:0]    mem_a [MAX_WORDS];
  logic [WORD_W-1:0]    mem_b [MAX_WORDS];
  logic                 clr_busy;
  logic [AW-1:0]        clr_addr;

  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   stop_r;
  logic               ok_r;
  logic               ans_r;
  logic [WORD_W-1:0]  rd_r;
  logic [IDX_W-1:0]   last_nz;

  // read stage
  logic               p_vld;
  logic [IDX_W-1:0]   p_idx;
  logic [WORD_W-1:0]  a_q;
  logic [WORD_W-1:0]  b_q;
  logic               ina_q;
  logic               inb_q;

  logic [IDX_W-1:0]   start_c;
  logic [IDX_W-1:0]   stop_c;
  logic               ok_c;
  logic               is_test;
  logic [IDX_W-1:0]   max_ab;
  logic [IDX_W-1:0]   min_ab;
  logic [WIDX_W-1:0]  lo_w;
  logic [WIDX_W-1:0]  hi_w;
  logic               req_bad;
  logic               range_bad;

  logic [WORD_W-1:0]  wa;
  logic [WORD_W-1:0]  wb;
  logic [WORD_W-1:0]  res;
  logic               wr_kind;
  logic               viol;
  logic [WIDX_W-1:0]  p_w;
  logic [WORD_W-1:0]  low_mask;
  logic [WORD_W-1:0]  high_mask;

  logic               a_we;
  logic [AW-1:0]      a_waddr;
  logic [WORD_W-1:0]  a_wdata;
  logic               b_we;
  logic [AW-1:0]      b_waddr;
  logic [WORD_W-1:0]  b_wdata;
  logic [AW-1:0]      rd_addr;
  logic [IDX_W-1:0]   size_a_next;

  assign max_ab    = (size_a > size_b) ? size_a : size_b;
  assign min_ab    = (size_a < size_b) ? size_a : size_b;
  assign lo_w      = lo_r[ELEM_W-1:BITSEL_W];
  assign hi_w      = hi_r[ELEM_W-1:BITSEL_W];
  assign req_bad   = (req_r > MAX_REQ);
  assign range_bad = (lo_r >= MAX_ELEM) || (hi_r >= MAX_ELEM);

  // walk bounds and acceptance for the latched item
  always_comb begin
    start_c = '0;
    stop_c  = '0;
    ok_c    = 1'b1;
    is_test = 1'b0;
    case (mode_r)
      MODE_WR_A, MODE_WR_B: begin
        ok_c = (widx_r < MAX_IDX);
      end
      MODE_SIZE_A, MODE_SIZE_B: begin
        ok_c = !req_bad;
      end
      MODE_UNION: begin
        stop_c = max_ab;
      end
      MODE_INTER: begin
        stop_c = min_ab;
      end
      MODE_DIFF: begin
        stop_c = size_a;
      end
      MODE_EQUAL, MODE_SUBSET, MODE_SUPERSET: begin
        stop_c  = max_ab;
        is_test = 1'b1;
      end
      MODE_MEMBER: begin
        if (lo_w < WIDX_W'(size_a)) begin
          start_c = lo_w[IDX_W-1:0];
          stop_c  = lo_w[IDX_W-1:0] + IDX_W'(1);
        end
      end
      MODE_SUBRANGE: begin
        ok_c = !range_bad;
        if (!range_bad && (hi_r >= lo_r)) stop_c = hi_w[IDX_W-1:0] + IDX_W'(1);
      end
      MODE_ADJUST: begin
        ok_c = !req_bad;
        if (!req_bad) begin
          start_c = size_a;
          stop_c  = req_r[IDX_W-1:0];
        end
      end
      MODE_RD_A: begin
        if (widx_r < size_a) begin
          start_c = widx_r;
          stop_c  = widx_r + IDX_W'(1);
        end
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
  end

  assign sts.clearing    = clr_busy;
  assign sts.walk_needed = (start_c < stop_c);
  assign sts.walk_last   = (idx == stop_r - IDX_W'(1));
  assign sts.out_free    = !out_valid || out_ready;

  // combine stage: words outside a size count as zero
  assign wa  = ina_q ? a_q : '0;
  assign wb  = inb_q ? b_q : '0;
  assign p_w = WIDX_W'(p_idx);

  always_comb begin
    if (p_w == lo_w)     low_mask = {WORD_W{1'b1}} << lo_r[BITSEL_W-1:0];
    else if (p_w > lo_w) low_mask = '1;
    else                 low_mask = '0;
    // ~x over the bit select is 15 - x
    if (p_w == hi_w)     high_mask = {WORD_W{1'b1}} >> (~hi_r[BITSEL_W-1:0]);
    else                 high_mask = '1;
  end

  always_comb begin
    res     = '0;
    wr_kind = 1'b0;
    viol    = 1'b0;
    case (mode_r)
      MODE_UNION: begin
        res     = wa | wb;
        wr_kind = 1'b1;
      end
      MODE_INTER: begin
        res     = wa & wb;
        wr_kind = 1'b1;
      end
      MODE_DIFF: begin
        res     = wa & ~wb;
        wr_kind = 1'b1;
      end
      MODE_SUBRANGE: begin
        res     = low_mask & high_mask;
        wr_kind = 1'b1;
      end
      MODE_ADJUST: begin
        wr_kind = 1'b1;
      end
      MODE_EQUAL:    viol = (wa != wb);
      MODE_SUBSET:   viol = ((wa & ~wb) != '0);
      MODE_SUPERSET: viol = ((wb & ~wa) != '0);
      default: ;
    endcase
  end

  // clearing pass: one word of each store per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == CLR_LAST) clr_busy <= 1'b0;
    end
  end

  assign rd_addr = idx[AW-1:0];
  assign a_we    = clr_busy || (cmd.setup && (mode_r == MODE_WR_A) && ok_c) ||
                   (p_vld && wr_kind);
  assign a_waddr = clr_busy ? clr_addr : (p_vld ? p_idx[AW-1:0] : widx_r[AW-1:0]);
  assign a_wdata = clr_busy ? '0 : (p_vld ? res : data_r);
  assign b_we    = clr_busy || (cmd.setup && (mode_r == MODE_WR_B) && ok_c);
  assign b_waddr = clr_busy ? clr_addr : widx_r[AW-1:0];
  assign b_wdata = clr_busy ? '0 : data_r;

  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_waddr] <= a_wdata;
    a_q <= mem_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) mem_b[b_waddr] <= b_wdata;
    b_q <= mem_b[rd_addr];
  end

  always_ff @(posedge clk) begin
    ina_q <= (idx < size_a);
    inb_q <= (idx < size_b);
    p_idx <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= cmd.walk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= mode_t'(in_mode);
      widx_r <= in_word_index;
      data_r <= in_data_word;
      req_r  <= in_size_request;
      lo_r   <= in_element_low;
      hi_r   <= in_element_high;
    end
  end

  // walk counter and accumulators
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      idx     <= start_c;
      stop_r  <= stop_c;
      ok_r    <= ok_c;
      ans_r   <= is_test;
      rd_r    <= '0;
      last_nz <= '0;
    end else begin
      if (cmd.walk) idx <= idx + IDX_W'(1);
      if (p_vld) begin
        if (viol) ans_r <= 1'b0;
        if (mode_r == MODE_MEMBER) ans_r <= wa[lo_r[BITSEL_W-1:0]];
        if (mode_r == MODE_RD_A) rd_r <= wa;
        // indices rise, so the last nonzero word seen sets the trimmed size
        if (wr_kind && (res != '0)) last_nz <= p_idx + IDX_W'(1);
      end
    end
  end

  always_comb begin
    size_a_next = size_a;
    case (mode_r)
      MODE_SIZE_A, MODE_ADJUST: begin
        if (ok_r) size_a_next = req_r[IDX_W-1:0];
      end
      MODE_UNION, MODE_INTER: begin
        size_a_next = trim_r ? last_nz : stop_r;
      end
      MODE_DIFF: begin
        size_a_next = trim_r ? last_nz : size_a;
      end
      MODE_SUBRANGE: begin
        if (ok_r) size_a_next = stop_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_r    <= 1'b0;
      size_a    <= '0;
      size_b    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) trim_r <= cfg_data;
      if (cmd.commit) begin
        size_a    <= size_a_next;
        out_valid <= 1'b1;
        if ((mode_r == MODE_SIZE_B) && ok_r) size_b <= req_r[IDX_W-1:0];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_ok        <= ok_r;
      out_answer    <= ans_r;
      out_read_word <= rd_r;
      out_size_now  <= size_a_next;
    end
  end

endmodule

// ===== design/bitmap_set_operation_unit.sv =====
// top level of the bitmap set operation unit: stream ports, sequencer, datapath
// depends on bsop_pkg, bsop_ctrl, bsop_dp
//
//   port group   dir   contents
//   s_*          in    one request item (mode in tuser, operands in tdata)
//   m_*          out   one result item per request
//   cfg_*        in    trim_results register write
//
// a request that walks n words (n up to MAX_WORDS) walks one word per cycle
// through the single read port of each store
// rst is synchronous; after reset a clearing pass zeroes both stores, one word per
// cycle until all MAX_WORDS words are zero, with s_tready held low
// a finished result waits in the output register while the next item is taken;
// a new result is only written once that register is free
module bitmap_set_operation_unit #(
  parameter int MAX_WORDS = bsop_pkg::DEF_MAX_WORDS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // word_index[7:0], data_word[23:8], size_request[39:24],
  // element_low[55:40], element_high[71:56]
  input  logic [bsop_pkg::S_TDATA_W-1:0]     s_tdata,
  // mode[3:0]
  input  logic [bsop_pkg::MODE_W-1:0]        s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // ok[0], answer[1], read_word[17:2], size_now[25:18], zero[31:26]
  output logic [bsop_pkg::M_TDATA_W-1:0]     m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data
);
  import bsop_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic              out_ok;
  logic              out_answer;
  logic [WORD_W-1:0] out_read_word;
  logic [IDX_W-1:0]  out_size_now;

  assign cfg_ready = 1'b1;

  bsop_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsop_dp #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (s_tuser),
    .in_word_index   (s_tdata[7:0]),
    .in_data_word    (s_tdata[23:8]),
    .in_size_request (s_tdata[39:24]),
    .in_element_low  (s_tdata[55:40]),
    .in_element_high (s_tdata[71:56]),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .out_ok          (out_ok),
    .out_answer      (out_answer),
    .out_read_word   (out_read_word),
    .out_size_now    (out_size_now)
  );

  assign m_tdata = {{(M_TDATA_W - M_OUT_W){1'b0}}, out_size_now, out_read_word,
                    out_answer, out_ok};

endmodule

// ===== design/bsop_chk.sv =====
// port-level checks for the bitmap set operation unit
// depends on bsop_pkg; bound to bitmap_set_operation_unit below
module bsop_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bsop_pkg::M_TDATA_W-1:0] m_tdata
);
  import bsop_pkg::*;

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again right after an item");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[M_TDATA_W-1:M_OUT_W] == '0))
    else $error("result padding not zero");

  // a read word comes only from the read mode, which gives no answer
  a_excl: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[17:2] != '0)) |-> !m_tdata[1])
    else $error("answer and read word both set");

  // a rejected item carries no answer and no read word
  a_reject: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[17:1] == '0))
    else $error("rejected item carries data");

endmodule

bind bitmap_set_operation_unit bsop_chk u_bsop_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
